// ===== sv/nc_pkg.sv =====
// Shared types, constants and the cell code function of the Nihilist letter unit.
package nc_pkg;

	localparam int CELLS     = 25;
	localparam int SIDE      = 5;
	localparam int LETTER_W  = 5;
	localparam int LABEL_W   = 10;
	localparam int CODE_W    = 24;
	localparam int NUM_W     = 25;
	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 50;
	localparam int KEY_SLOTS = 8;
	localparam int KEY_LEN_W = 4;
	localparam int CELL_IDX_W = 5;

	localparam logic [BYTE_W-1:0] ASCII_A = 8'd97;
	localparam logic [BYTE_W-1:0] ASCII_I = 8'd105;
	localparam logic [BYTE_W-1:0] ASCII_J = 8'd106;
	localparam logic [BYTE_W-1:0] ASCII_Z = 8'd122;

	localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
	localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;

	localparam logic ACT_ENCRYPT = 1'b0;
	localparam logic ACT_DECRYPT = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELLS_FIRST   = 3'd0,
		REG_CELLS_MIDDLE  = 3'd1,
		REG_CELLS_LAST    = 3'd2,
		REG_COLUMN_LABELS = 3'd3,
		REG_ROW_LABELS    = 3'd4,
		REG_KEY_LETTERS   = 3'd5,
		REG_KEY_LENGTH    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [CELLS-1:0][LETTER_W-1:0] letter;
		logic [CELLS-1:0][CODE_W-1:0]   code;
		logic [CELLS-1:0]               first;
		logic [KEY_SLOTS*LETTER_W-1:0]  key_letters;
		logic [KEY_LEN_W-1:0]           key_length;
	} sq_cfg_t;

	function automatic logic [CODE_W-1:0] cell_code(input logic [LABEL_W-1:0] h,
			input logic [LABEL_W-1:0] v);
		logic [CODE_W-1:0] hx;
		logic [CODE_W-1:0] vx;
		hx = CODE_W'(h);
		vx = CODE_W'(v);
		if (v < LABEL_W'(10)) begin
			return hx * CODE_W'(10) + vx;
		end else if (v < LABEL_W'(100)) begin
			return hx * CODE_W'(100) + vx;
		end else if (v < LABEL_W'(1000)) begin
			return hx * CODE_W'(1000) + vx;
		end
		return hx * CODE_W'(10000) + vx;
	endfunction

endpackage

// ===== sv/nc_ifs.sv =====
// Channel interfaces of the Nihilist letter unit: input, result and configuration.
interface nc_in_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic                        message_start;
	logic [nc_pkg::BYTE_W-1:0]   plain_byte;
	logic [nc_pkg::NUM_W-1:0]    cipher_code;

	modport source (output valid, action, message_start, plain_byte, cipher_code,
		input ready);
	modport sink (input valid, action, message_start, plain_byte, cipher_code,
		output ready);
endinterface

interface nc_out_if;
	logic                        valid;
	logic                        ready;
	logic [nc_pkg::NUM_W-1:0]    cipher_number;
	logic [nc_pkg::BYTE_W-1:0]   plain_letter;
	logic                        not_found;

	modport source (output valid, cipher_number, plain_letter, not_found, input ready);
	modport sink (input valid, cipher_number, plain_letter, not_found, output ready);
endinterface

interface nc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [nc_pkg::CFG_IDX_W-1:0]  index;
	logic [nc_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/nihilist_cipher_letter_unit.sv =====
// Top level of the Nihilist letter cipher unit.
// Usage:
//   msg_in carries one word per letter: action (encrypt or decrypt), message_start,
//   plain_byte for encrypt and cipher_code for decrypt. msg_out returns
//   cipher_number, plain_letter and not_found. cfg writes the square letters,
//   the column and row labels, the key letters and the key length by index;
//   cfg.ready is always high and writes belong to idle periods.
//   An encrypt word whose byte is not a lowercase letter is taken and yields
//   no result; every other word yields exactly one result.
//   A word passes through the input register, the key and letter code lookup
//   register and the result register, which drives msg_out. One word enters
//   per cycle when msg_out is not stalled, set by the lookup and compare paths
//   over the 25 cells that each fit one stage.
//   A stalled receiver holds the result register; the stages behind it fill
//   and msg_in.ready falls once all three hold words.
//   Reset clears the configuration registers and valid flags to zero, the key
//   length to one and the key position to letter zero.
module nihilist_cipher_letter_unit #(
	parameter int KEY_LETTERS_MAX = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	nc_in_if.sink    msg_in,
	nc_out_if.source msg_out,
	nc_cfg_if.sink   cfg
);
	import nc_pkg::*;

	sq_cfg_t sq;

	nc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sq     (sq)
	);

	nc_core #(
		.KEY_LETTERS_MAX(KEY_LETTERS_MAX)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg_in  (msg_in),
		.msg_out (msg_out),
		.sq      (sq)
	);

endmodule

// ===== sv/nc_cfg.sv =====
// Configuration registers and the derived cell code table of the letter square.
module nc_cfg (
	input  logic             clk,
	input  logic             arst_n,
	nc_cfg_if.sink           cfg,
	output nc_pkg::sq_cfg_t  sq
);
	import nc_pkg::*;

	logic [CELLS*LETTER_W-1:0]     letters_q;
	logic [SIDE*LABEL_W-1:0]       columns_q;
	logic [SIDE*LABEL_W-1:0]       rows_q;
	logic [KEY_SLOTS*LETTER_W-1:0] keys_q;
	logic [KEY_LEN_W-1:0]          key_len_q;
	logic                          wr;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid & cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letters_q <= '0;
			columns_q <= '0;
			rows_q    <= '0;
			keys_q    <= '0;
			key_len_q <= KEY_LEN_W'(1);
		end else if (wr) begin
			unique case (cfg.index)
				REG_CELLS_FIRST:   letters_q[44:0]   <= cfg.data[44:0];
				REG_CELLS_MIDDLE:  letters_q[84:45]  <= cfg.data[39:0];
				REG_CELLS_LAST:    letters_q[124:85] <= cfg.data[39:0];
				REG_COLUMN_LABELS: columns_q <= cfg.data[SIDE*LABEL_W-1:0];
				REG_ROW_LABELS:    rows_q    <= cfg.data[SIDE*LABEL_W-1:0];
				REG_KEY_LETTERS:   keys_q    <= cfg.data[KEY_SLOTS*LETTER_W-1:0];
				REG_KEY_LENGTH:    key_len_q <= cfg.data[KEY_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sq = '0;
		sq.key_letters = keys_q;
		sq.key_length  = key_len_q;
		for (int i = 0; i < CELLS; i++) begin
			sq.letter[i] = letters_q[i*LETTER_W +: LETTER_W];
		end
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				sq.code[r*SIDE+c] = cell_code(columns_q[c*LABEL_W +: LABEL_W],
					rows_q[r*LABEL_W +: LABEL_W]);
			end
		end
		for (int i = 0; i < CELLS; i++) begin
			sq.first[i] = 1'b1;
			for (int j = 0; j < i; j++) begin
				if (letters_q[j*LETTER_W +: LETTER_W] == letters_q[i*LETTER_W +: LETTER_W]) begin
					sq.first[i] = 1'b0;
				end
			end
		end
	end

endmodule

// ===== sv/nc_key_seq.sv =====
// Key position counter advanced at each accepted word that yields a result and restarted at message_start.
module nc_key_seq #(
	parameter int KEY_LETTERS_MAX = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic                      restart,
	input  logic                      advance,
	input  logic [nc_pkg::KEY_LEN_W-1:0] key_length,
	output logic [(KEY_LETTERS_MAX > 1 ? $clog2(KEY_LETTERS_MAX) : 1)-1:0] pos
);
	import nc_pkg::*;

	localparam int POS_W = KEY_LETTERS_MAX > 1 ? $clog2(KEY_LETTERS_MAX) : 1;

	logic [POS_W-1:0]     key_pos_q;
	logic [POS_W-1:0]     pos_start;
	logic [KEY_LEN_W-1:0] len;
	logic [KEY_LEN_W-1:0] pos_inc;

	always_comb begin
		len = key_length;
		if (len == '0) begin
			len = KEY_LEN_W'(1);
		end
		if (len > KEY_LEN_W'(KEY_LETTERS_MAX)) begin
			len = KEY_LEN_W'(KEY_LETTERS_MAX);
		end
		pos_start = restart ? '0 : key_pos_q;
		pos = (KEY_LEN_W'(pos_start) >= len) ? '0 : pos_start;
		pos_inc = KEY_LEN_W'(pos) + KEY_LEN_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pos_q <= '0;
		end else if (take) begin
			if (advance) begin
				key_pos_q <= (pos_inc >= len) ? '0 : pos_inc[POS_W-1:0];
			end else if (restart) begin
				key_pos_q <= '0;
			end
		end
	end

endmodule

// ===== sv/nc_core.sv =====
// Input register, code lookup stage and result register of the letter cipher.
module nc_core #(
	parameter int KEY_LETTERS_MAX = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	nc_in_if.sink            msg_in,
	nc_out_if.source         msg_out,
	input  nc_pkg::sq_cfg_t  sq
);
	import nc_pkg::*;

	localparam int POS_W = KEY_LETTERS_MAX > 1 ? $clog2(KEY_LETTERS_MAX) : 1;

	function automatic logic [CELL_IDX_W-1:0] find_cell(input sq_cfg_t s,
			input logic [LETTER_W-1:0] l);
		logic [CELL_IDX_W-1:0] idx;
		idx = '0;
		for (int i = CELLS - 1; i >= 0; i--) begin
			if (s.letter[i] == l) begin
				idx = CELL_IDX_W'(i);
			end
		end
		return idx;
	endfunction

	logic                  take;
	logic                  is_letter;
	logic                  drop;
	logic [BYTE_W-1:0]     folded;
	logic [POS_W-1:0]      pos;
	logic                  out_en;
	logic                  s2_en;
	logic                  s1_en;

	logic                  v_s1;
	logic                  action_s1;
	logic [LETTER_W-1:0]   letter_s1;
	logic [NUM_W-1:0]      code_s1;
	logic [POS_W-1:0]      pos_s1;

	logic                  v_s2;
	logic                  action_s2;
	logic [CODE_W-1:0]     key_code_s2;
	logic [CODE_W-1:0]     msg_code_s2;
	logic [NUM_W-1:0]      code_s2;

	logic                  out_v_q;
	logic [NUM_W-1:0]      number_q;
	logic [BYTE_W-1:0]     plain_q;
	logic                  not_found_q;

	logic [LETTER_W-1:0]   key_letter;
	logic [CODE_W-1:0]     key_code;
	logic [CODE_W-1:0]     msg_code;
	logic [NUM_W-1:0]      target;
	logic                  hit;
	logic [LETTER_W-1:0]   hit_letter;
	logic [NUM_W-1:0]      number_d;
	logic [BYTE_W-1:0]     plain_d;
	logic                  not_found_d;

	assign out_en = !out_v_q || msg_out.ready;
	assign s2_en  = !v_s2 || out_en;
	assign s1_en  = !v_s1 || s2_en;
	assign msg_in.ready = s1_en;
	assign take = msg_in.valid && msg_in.ready;

	assign folded = (msg_in.plain_byte == ASCII_J) ? ASCII_I : msg_in.plain_byte;
	assign is_letter = (folded >= ASCII_A) && (folded <= ASCII_Z);
	assign drop = (msg_in.action == ACT_ENCRYPT) && !is_letter;

	nc_key_seq #(
		.KEY_LETTERS_MAX(KEY_LETTERS_MAX)
	) u_key_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.restart    (msg_in.message_start),
		.advance    (!drop),
		.key_length (sq.key_length),
		.pos        (pos)
	);

	always_comb begin
		key_letter = sq.key_letters[pos_s1*LETTER_W +: LETTER_W];
		if (key_letter == LETTER_J) begin
			key_letter = LETTER_I;
		end
		key_code = sq.code[find_cell(sq, key_letter)];
		msg_code = sq.code[find_cell(sq, letter_s1)];
	end

	always_comb begin
		target = code_s2 - NUM_W'(key_code_s2);
		hit = 1'b0;
		hit_letter = '0;
		for (int i = CELLS - 1; i >= 0; i--) begin
			if (sq.first[i] && NUM_W'(sq.code[i]) == target) begin
				hit = 1'b1;
				hit_letter = sq.letter[i];
			end
		end
		if (code_s2 < NUM_W'(key_code_s2)) begin
			hit = 1'b0;
		end
		if (action_s2 == ACT_ENCRYPT) begin
			number_d    = NUM_W'(msg_code_s2) + NUM_W'(key_code_s2);
			plain_d     = '0;
			not_found_d = 1'b0;
		end else begin
			number_d    = '0;
			plain_d     = hit ? ASCII_A + BYTE_W'(hit_letter) : '0;
			not_found_d = !hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_en) begin
				v_s1 <= take && !drop;
			end
			if (s2_en) begin
				v_s2 <= v_s1;
			end
			if (out_en) begin
				out_v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en) begin
			action_s1 <= msg_in.action;
			letter_s1 <= LETTER_W'(folded - ASCII_A);
			code_s1   <= msg_in.cipher_code;
			pos_s1    <= pos;
		end
		if (s2_en) begin
			action_s2   <= action_s1;
			key_code_s2 <= key_code;
			msg_code_s2 <= msg_code;
			code_s2     <= code_s1;
		end
		if (out_en) begin
			number_q    <= number_d;
			plain_q     <= plain_d;
			not_found_q <= not_found_d;
		end
	end

	assign msg_out.valid         = out_v_q;
	assign msg_out.cipher_number = number_q;
	assign msg_out.plain_letter  = plain_q;
	assign msg_out.not_found     = not_found_q;

endmodule
